// ----- hdl/rpac_pkg.sv -----
// rpac_pkg: shared types, constants and the arctangent table for the point rotator
// used by rpac_prep, rpac_cell, rpac_post and rotate_point_about_center
// no dependencies
package rpac_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 20;
    localparam int DIFF_W  = 33;
    localparam int PHASE_W = 32;
    localparam int GUARD_BITS = 8;
    // datapath width covers rotated offsets scaled by guard bits plus cordic growth
    localparam int XW = 43;

    // 2^40 / (2*pi), rounded
    localparam logic signed [38:0] RAD_TO_TURN = 39'sd174992710548;
    // 1/K in Q30
    localparam logic signed [30:0] INV_GAIN = 31'sd652032874;
    localparam int GAIN_SHIFT = 30 - GUARD_BITS;

    localparam logic signed [35:0] SUM_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SUM_MIN = -36'sd2147483648;

    // one word in flight along the cordic chain
    typedef struct packed {
        logic                       valid;
        logic signed [XW-1:0]       x;
        logic signed [XW-1:0]       y;
        logic signed [PHASE_W-1:0]  z;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
    } cdata_t;

    // atan(2^-i) in phase units, 2^32 per turn
    function automatic logic [PHASE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [PHASE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            5'd30:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/rotate_point_about_center.sv -----
// Rotates a Q15.16 point about a center by a Q3.16 angle (counter-clockwise) with a
// gain-compensated CORDIC. The block takes a new word in every cycle and busy stays low.
// Each result passes through four registered front-end
// stages (offset and phase multiply, quadrant fold, gain multiply, rounding), one cell per
// micro-rotation, and one output stage for rounding, center add and saturation. The receiver
// has no way to stall the pipeline, so the result must be taken in the cycle done is high.
// top level; instantiates rpac_prep, rpac_cell and rpac_post, uses rpac_pkg
module rotate_point_about_center #(
    parameter int CORDIC_STAGES = rpac_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = rpac_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rpac_pkg::COORD_W-1:0] center_x,
    input  logic signed [rpac_pkg::COORD_W-1:0] center_y,
    input  logic signed [rpac_pkg::COORD_W-1:0] point_x,
    input  logic signed [rpac_pkg::COORD_W-1:0] point_y,
    input  logic signed [rpac_pkg::ANGLE_W-1:0] angle,
    output logic                                done,
    output logic signed [rpac_pkg::COORD_W-1:0] rotated_x,
    output logic signed [rpac_pkg::COORD_W-1:0] rotated_y,
    output logic                                saturated
);
    import rpac_pkg::*;

    localparam int LATENCY = CORDIC_STAGES + 5;

    cdata_t chain [CORDIC_STAGES+1];
    logic   accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    rpac_prep #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .center_x (center_x),
        .center_y (center_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .angle    (angle),
        .out      (chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        rpac_cell #(
            .IDX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_word  (chain[i]),
            .out_word (chain[i+1])
        );
    end

    rpac_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (chain[CORDIC_STAGES]),
        .done      (done),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .saturated (saturated)
    );

    // every accepted word comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not come out after the pipeline latency");

    // no result without a matching start
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result word without a matching start");

    // a clamped result sits on a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |->
            (rotated_x == 32'sh7fff_ffff) || (rotated_x == 32'sh8000_0000) ||
            (rotated_y == 32'sh7fff_ffff) || (rotated_y == 32'sh8000_0000))
        else $error("saturated flag set but no coordinate at a bound");

    // the cordic residual angle stays within one eighth of a turn either way at the chain output
    a_resid: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CORDIC_STAGES].valid |->
            (chain[CORDIC_STAGES].z <= 32'sh2000_0000) &&
            (chain[CORDIC_STAGES].z >= -32'sh2000_0000))
        else $error("cordic residual angle out of range");

endmodule

// ----- hdl/rpac_prep.sv -----
// rpac_prep: front end of the rotator, four stages
// offset, angle to phase, quadrant fold and gain compensation; uses rpac_pkg
module rpac_prep #(
    parameter int FRACTION_BITS = rpac_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [rpac_pkg::COORD_W-1:0]    center_x,
    input  logic signed [rpac_pkg::COORD_W-1:0]    center_y,
    input  logic signed [rpac_pkg::COORD_W-1:0]    point_x,
    input  logic signed [rpac_pkg::COORD_W-1:0]    point_y,
    input  logic signed [rpac_pkg::ANGLE_W-1:0]    angle,
    output rpac_pkg::cdata_t                       out
);
    import rpac_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic signed [63:0] PHASE_RND = 64'sd1 <<< (FRACTION_BITS + 7);
    localparam logic signed [63:0] GAIN_RND = 64'sd1 <<< (GAIN_SHIFT - 1);

    // stage 1
    logic                      v1_reg;
    logic signed [DIFF_W-1:0]  dx1_reg, dy1_reg;
    logic signed [63:0]        prod1_reg;
    logic signed [COORD_W-1:0] cx1_reg, cy1_reg;
    // stage 2
    logic                      v2_reg;
    logic signed [DIFF_W-1:0]  qx2_reg, qy2_reg;
    logic signed [PHASE_W-1:0] z2_reg;
    logic signed [COORD_W-1:0] cx2_reg, cy2_reg;
    // stage 3
    logic                      v3_reg;
    logic signed [63:0]        gx3_reg, gy3_reg;
    logic signed [PHASE_W-1:0] z3_reg;
    logic signed [COORD_W-1:0] cx3_reg, cy3_reg;
    // stage 4
    logic                      v4_reg;
    logic signed [XW-1:0]      x4_reg, y4_reg;
    logic signed [PHASE_W-1:0] z4_reg;
    logic signed [COORD_W-1:0] cx4_reg, cy4_reg;

    logic signed [63:0]        phase_sum;
    logic [PHASE_W-1:0]        phase;
    logic [PHASE_W-1:0]        phase_bias;
    logic [1:0]                quad;
    logic signed [DIFF_W-1:0]  qx_next, qy_next;
    logic signed [PHASE_W-1:0] z_next;
    logic signed [63:0]        gx_sum, gy_sum;

    always_comb
    begin
        phase_sum  = prod1_reg + PHASE_RND;
        phase      = PHASE_W'(phase_sum >>> (FRACTION_BITS + 8));
        phase_bias = phase + 32'h2000_0000;
        quad       = phase_bias[PHASE_W-1:PHASE_W-2];
        z_next     = signed'(phase - {quad, 30'd0});
        case (quad)
            QUAD_0:
            begin
                qx_next = dx1_reg;
                qy_next = dy1_reg;
            end
            QUAD_1:
            begin
                qx_next = -dy1_reg;
                qy_next = dx1_reg;
            end
            QUAD_2:
            begin
                qx_next = -dx1_reg;
                qy_next = -dy1_reg;
            end
            QUAD_3:
            begin
                qx_next = dy1_reg;
                qy_next = -dx1_reg;
            end
            default:
            begin
                qx_next = dx1_reg;
                qy_next = dy1_reg;
            end
        endcase
        gx_sum = gx3_reg + GAIN_RND;
        gy_sum = gy3_reg + GAIN_RND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg   <= DIFF_W'(point_x) - DIFF_W'(center_x);
        dy1_reg   <= DIFF_W'(point_y) - DIFF_W'(center_y);
        prod1_reg <= 64'(angle) * 64'(RAD_TO_TURN);
        cx1_reg   <= center_x;
        cy1_reg   <= center_y;

        qx2_reg   <= qx_next;
        qy2_reg   <= qy_next;
        z2_reg    <= z_next;
        cx2_reg   <= cx1_reg;
        cy2_reg   <= cy1_reg;

        gx3_reg   <= 64'(qx2_reg) * 64'(INV_GAIN);
        gy3_reg   <= 64'(qy2_reg) * 64'(INV_GAIN);
        z3_reg    <= z2_reg;
        cx3_reg   <= cx2_reg;
        cy3_reg   <= cy2_reg;

        x4_reg    <= XW'(gx_sum >>> GAIN_SHIFT);
        y4_reg    <= XW'(gy_sum >>> GAIN_SHIFT);
        z4_reg    <= z3_reg;
        cx4_reg   <= cx3_reg;
        cy4_reg   <= cy3_reg;
    end

    assign out = {v4_reg, x4_reg, y4_reg, z4_reg, cx4_reg, cy4_reg};

endmodule

// ----- hdl/rpac_cell.sv -----
// rpac_cell: one cordic micro-rotation with its pipeline register
// shift amount and arctangent fixed by IDX; uses rpac_pkg
module rpac_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rpac_pkg::cdata_t in_word,
    output rpac_pkg::cdata_t out_word
);
    import rpac_pkg::*;

    localparam logic signed [PHASE_W-1:0] ATAN = signed'(atan_turn(5'(IDX)));

    logic                      valid_reg;
    logic signed [XW-1:0]      x_reg, y_reg;
    logic signed [PHASE_W-1:0] z_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    cdata_t                    word_next;
    logic signed [XW-1:0]      xs, ys;

    always_comb
    begin
        xs        = in_word.x >>> IDX;
        ys        = in_word.y >>> IDX;
        word_next = in_word;
        if (!in_word.z[PHASE_W-1])
        begin
            word_next.x = in_word.x - ys;
            word_next.y = in_word.y + xs;
            word_next.z = in_word.z - ATAN;
        end
        else
        begin
            word_next.x = in_word.x + ys;
            word_next.y = in_word.y - xs;
            word_next.z = in_word.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= word_next.valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= word_next.x;
        y_reg  <= word_next.y;
        z_reg  <= word_next.z;
        cx_reg <= word_next.cx;
        cy_reg <= word_next.cy;
    end

    assign out_word = {valid_reg, x_reg, y_reg, z_reg, cx_reg, cy_reg};

endmodule

// ----- hdl/rpac_post.sv -----
// rpac_post: drops the guard bits, adds the center back and saturates
// registered result word with strobe; uses rpac_pkg
module rpac_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpac_pkg::cdata_t                    in_word,
    output logic                                done,
    output logic signed [rpac_pkg::COORD_W-1:0] rotated_x,
    output logic signed [rpac_pkg::COORD_W-1:0] rotated_y,
    output logic                                saturated
);
    import rpac_pkg::*;

    localparam int RW = XW - GUARD_BITS;
    localparam logic signed [XW-1:0] RND = XW'(1) <<< (GUARD_BITS - 1);

    logic                      done_reg;
    logic signed [COORD_W-1:0] rx_reg, ry_reg;
    logic                      sat_reg;

    logic signed [RW-1:0]      xr, yr;
    logic signed [35:0]        sx, sy;
    logic signed [COORD_W-1:0] rx_next, ry_next;
    logic                      satx, saty;

    always_comb
    begin
        xr = RW'((in_word.x + RND) >>> GUARD_BITS);
        yr = RW'((in_word.y + RND) >>> GUARD_BITS);
        sx = 36'(xr) + 36'(in_word.cx);
        sy = 36'(yr) + 36'(in_word.cy);
        satx = 1'b1;
        saty = 1'b1;
        if (sx > SUM_MAX)
            rx_next = COORD_W'(SUM_MAX);
        else if (sx < SUM_MIN)
            rx_next = COORD_W'(SUM_MIN);
        else
        begin
            rx_next = COORD_W'(sx);
            satx    = 1'b0;
        end
        if (sy > SUM_MAX)
            ry_next = COORD_W'(SUM_MAX);
        else if (sy < SUM_MIN)
            ry_next = COORD_W'(SUM_MIN);
        else
        begin
            ry_next = COORD_W'(sy);
            saty    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_word.valid;
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        sat_reg <= satx | saty;
    end

    assign done      = done_reg;
    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;
    assign saturated = sat_reg;

endmodule

// ----- tb/rotate_point_about_center_tb.sv -----
// rotate_point_about_center_tb: self-checking bench for the fixed-point point rotator
// drives directed and random words, predicts each untyped result, takes typed rows as given
// and checks each result field by field; depends on rpac_pkg and rotate_point_about_center
`timescale 1ns / 100ps

module rotate_point_about_center_tb;

    localparam int CW = rpac_pkg::COORD_W;
    localparam int AW = rpac_pkg::ANGLE_W;
    localparam int STAGES = rpac_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC = rpac_pkg::FRACTION_BITS_DEF;
    localparam int GUARD = rpac_pkg::GUARD_BITS;

    localparam longint RAD_TURN_Q40 = 64'sd174992710548;
    localparam longint INV_K_Q30 = 64'sd652032874;

    // atan(2^-i) in phase units, one turn is 2^32
    localparam longint ATAN_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81,
        41, 20, 10, 5,
        3, 1, 1, 0
    };

    localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] ONE = 32'sd65536;
    localparam logic signed [AW-1:0] ANG_MAX = 20'sh7FFFF;
    localparam logic signed [AW-1:0] ANG_MIN = 20'sh80000;
    localparam logic signed [AW-1:0] ANG_PI = 20'sd205887;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [AW-1:0] ANG_QTR_PI = 20'sd51472;
    localparam logic signed [AW-1:0] ANG_M3QTR_PI = -20'sd154416;
    localparam logic signed [AW-1:0] ANG_ONE = 20'sd65536;

    localparam int N_RANDOM = 800;
    localparam int N_DIRECTED = 18;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [AW-1:0] ang;
    } point_word_t;

    typedef struct packed {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic                 sat;
    } rot_result_t;

    typedef struct packed {
        point_word_t w;
        logic        typed;
        rot_result_t r;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [AW-1:0] angle;
    logic                 done;
    logic signed [CW-1:0] rotated_x;
    logic signed [CW-1:0] rotated_y;
    logic                 saturated;

    // a typed expectation rides along with the word it belongs to
    logic        use_typed;
    rot_result_t typed_res;

    rot_result_t awaited_points [$];
    int          errors;

    // typed rows: point on the center stays put, far opposite points clamp both sides
    localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 20'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
        '{'{CMAX, CMAX, CMAX, CMAX, ANG_MAX}, 1'b1, '{CMAX, CMAX, 1'b0}},
        '{'{CMIN, CMIN, CMIN, CMIN, ANG_MIN}, 1'b1, '{CMIN, CMIN, 1'b0}},
        '{'{CMAX, CMAX, CMIN, CMIN, ANG_PI}, 1'b1, '{CMAX, CMAX, 1'b1}},
        '{'{CMIN, CMIN, CMAX, CMAX, ANG_PI}, 1'b1, '{CMIN, CMIN, 1'b1}},
        '{'{32'sd0, 32'sd0, ONE, 32'sd0, ANG_HALF_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 5 * ONE, 32'sd0, ANG_ONE}, 1'b0, '0},
        '{'{ONE, 2 * ONE, 3 * ONE, -ONE, -ANG_HALF_PI}, 1'b0, '0},
        '{'{-ONE, ONE, 32'sd0, 32'sd0, ANG_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, ONE, ONE, -ANG_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 100 * ONE, -7 * ONE, ANG_QTR_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, -100 * ONE, 7 * ONE, ANG_M3QTR_PI}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, ONE, 32'sd0, ANG_MAX}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, ONE, 32'sd0, ANG_MIN}, 1'b0, '0},
        '{'{CMIN, 32'sd0, CMAX, 32'sd0, 20'sd0}, 1'b0, '0},
        '{'{32'sh7FF0_0000, 32'sd0, 32'sh7FF0_0000, -32'sh0100_0000, ANG_HALF_PI}, 1'b0, '0},
        '{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 20'shAAAAA},
          1'b0, '0},
        '{'{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA, 20'sh55555},
          1'b0, '0}
    };

    rotate_point_about_center dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .center_x  (center_x),
        .center_y  (center_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .angle     (angle),
        .done      (done),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic rot_result_t rotated_point(input point_word_t w);
        longint      cx, cy, dx, dy, tmp, x, y, z, xs, ys;
        logic [31:0] phase, quad, resid;
        rot_result_t r;
        cx = longint'(w.cx);
        cy = longint'(w.cy);
        dx = longint'(w.px) - cx;
        dy = longint'(w.py) - cy;
        // radians to a 32-bit phase, the wrap of which is the reduction mod 2*pi
        tmp = (longint'(w.ang) * RAD_TURN_Q40 + (64'sd1 <<< (FRAC + 7))) >>> (FRAC + 8);
        phase = tmp[31:0];
        quad = (phase + 32'h2000_0000) >> 30;
        resid = phase - (quad << 30);
        z = longint'(signed'(resid));
        case (quad)
            32'd1:
            begin
                tmp = dx;
                dx = -dy;
                dy = tmp;
            end
            32'd2:
            begin
                dx = -dx;
                dy = -dy;
            end
            32'd3:
            begin
                tmp = dx;
                dx = dy;
                dy = -tmp;
            end
            default:
            begin
            end
        endcase
        x = (dx * INV_K_Q30 + (64'sd1 <<< 21)) >>> (30 - GUARD);
        y = (dy * INV_K_Q30 + (64'sd1 <<< 21)) >>> (30 - GUARD);
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        x = ((x + (64'sd1 <<< (GUARD - 1))) >>> GUARD) + cx;
        y = ((y + (64'sd1 <<< (GUARD - 1))) >>> GUARD) + cy;
        r.sat = 1'b0;
        if (x > longint'(CMAX))
        begin
            x = longint'(CMAX);
            r.sat = 1'b1;
        end
        else if (x < longint'(CMIN))
        begin
            x = longint'(CMIN);
            r.sat = 1'b1;
        end
        if (y > longint'(CMAX))
        begin
            y = longint'(CMAX);
            r.sat = 1'b1;
        end
        else if (y < longint'(CMIN))
        begin
            y = longint'(CMIN);
            r.sat = 1'b1;
        end
        r.rx = x[31:0];
        r.ry = y[31:0];
        return r;
    endfunction

    function automatic point_word_t random_word();
        point_word_t w;
        int          mode;
        mode = $urandom_range(7);
        w.cx = $urandom;
        w.cy = $urandom;
        w.px = $urandom;
        w.py = $urandom;
        w.ang = AW'($urandom);
        case (mode)
            0, 1:
            begin
                // modest coordinates stay clear of clamping
                w.cx = w.cx >>> 8;
                w.cy = w.cy >>> 8;
                w.px = w.px >>> 8;
                w.py = w.py >>> 8;
            end
            2:
            begin
                w.cx = '0;
                w.cy = '0;
            end
            3:
            begin
                // polar form: distance along x, about the origin
                w.cx = '0;
                w.cy = '0;
                w.py = '0;
                w.px = w.px >>> $urandom_range(12);
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    task automatic note_error(input string what, input rot_result_t want, input rot_result_t got);
        errors++;
        if (errors <= 10)
            $display("%t mismatch (%s): expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                     $realtime, what, want.rx, want.ry, want.sat, got.rx, got.ry, got.sat);
    endtask

    // result check and expectation capture, both on the pre-edge values
    always @(posedge clk)
    begin
        point_word_t word;
        rot_result_t got, want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{rotated_x, rotated_y, saturated};
                if (awaited_points.size() == 0)
                    note_error("unexpected word", '0, got);
                else
                begin
                    want = awaited_points.pop_front();
                    if (got.rx !== want.rx)
                        note_error("rotated_x", want, got);
                    else if (got.ry !== want.ry)
                        note_error("rotated_y", want, got);
                    else if (got.sat !== want.sat)
                        note_error("saturated", want, got);
                end
            end
            if (start && !busy)
            begin
                word = '{center_x, center_y, point_x, point_y, angle};
                awaited_points.push_back(use_typed ? typed_res : rotated_point(word));
            end
        end
    end

    task automatic send_word(input point_word_t w, input logic typed, input rot_result_t r);
        start <= 1'b1;
        center_x <= w.cx;
        center_y <= w.cy;
        point_x <= w.px;
        point_y <= w.py;
        angle <= w.ang;
        use_typed <= typed;
        typed_res <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_points.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        center_x <= '0;
        center_y <= '0;
        point_x <= '0;
        point_y <= '0;
        angle <= '0;
        use_typed <= 1'b0;
        typed_res <= '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
        begin
            idle_gap();
            send_word(DIR_ROWS[k].w, DIR_ROWS[k].typed, DIR_ROWS[k].r);
        end
        drain();

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == 600)
                drain();
            // back-to-back stretch through the middle of the run
            if (k < 300 || k >= 500)
                idle_gap();
            send_word(random_word(), 1'b0, '0);
        end
        drain();
        repeat (2 * STAGES)
            @(posedge clk);

        if (errors == 0)
            $display("** rotate_point_about_center: PASSED **");
        else
            $display("** rotate_point_about_center: FAILED **");
        $finish;
    end

    initial
    begin
        #400000;
        $display("** rotate_point_about_center: FAILED **");
        $finish;
    end

endmodule
